// ===== rtl/vmpg_pkg.sv =====
`timescale 1ns / 1ps
// vmpg_pkg: types, codes, constants and small arithmetic helpers for the
// vibration motor pattern generator. No dependencies.

package vmpg_pkg;

    localparam int unsigned PIN_W = 6;
    // highest motor number that may drive a pin
    localparam logic [2:0] MOTOR_COUNT = 3'd6;

    typedef enum logic [1:0] {
        FUNC_START   = 2'd0,
        FUNC_STOP    = 2'd1,
        FUNC_PATTERN = 2'd2,
        FUNC_COUNT   = 2'd3
    } func_t;

    localparam logic [2:0] PAT_ON      = 3'd0;
    localparam logic [2:0] PAT_PULSE6  = 3'd1;
    localparam logic [2:0] PAT_PULSE10 = 3'd2;
    localparam logic [2:0] PAT_PULSE3  = 3'd3;
    localparam logic [2:0] PAT_BURST2  = 3'd4;
    localparam logic [2:0] PAT_BURST3  = 3'd5;
    localparam logic [2:0] PAT_LAST    = 3'd5;

    localparam logic [2:0] STOP_GRADE  = 3'd0;

    typedef struct packed {
        func_t       func;
        logic [2:0]  grade;
        logic [15:0] duration;
    } in_item_t;

    typedef struct packed {
        logic [PIN_W-1:0] motor_drive;
        logic             running;
        logic [15:0]      remaining;
        logic [2:0]       pattern;
    } out_item_t;

    function automatic logic [2:0] grade_to_motor(input logic [2:0] grade);
        logic [2:0] m;
        case (grade)
            3'd0, 3'd1: m = 3'd5;
            3'd2:       m = 3'd6;
            3'd3:       m = 3'd4;
            3'd4:       m = 3'd3;
            3'd5:       m = 3'd2;
            3'd6:       m = 3'd1;
            default:    m = 3'd3;
        endcase
        return m;
    endfunction

    // residue modulo 3 by summing base-4 digits
    function automatic logic [1:0] mod3_u11(input logic [10:0] x);
        logic [4:0] s1;
        logic [2:0] s2;
        logic [2:0] r;
        s1 = {3'b0, x[1:0]} + {3'b0, x[3:2]} + {3'b0, x[5:4]} + {3'b0, x[7:6]}
           + {3'b0, x[9:8]} + {4'b0, x[10]};
        s2 = {1'b0, s1[1:0]} + {1'b0, s1[3:2]} + {2'b0, s1[4]};
        if (s2 >= 3'd6) begin
            r = s2 - 3'd6;
        end else if (s2 >= 3'd3) begin
            r = s2 - 3'd3;
        end else begin
            r = s2;
        end
        return r[1:0];
    endfunction

    // parity of c/6, c/10, c/3, c/9 by reciprocal multiply (exact for 8 bits)
    function automatic logic odd_div6(input logic [7:0] c);
        logic [15:0] p;
        p = {8'b0, c} * 16'd171;
        return p[10];
    endfunction

    function automatic logic odd_div10(input logic [7:0] c);
        logic [15:0] p;
        p = {8'b0, c} * 16'd205;
        return p[11];
    endfunction

    function automatic logic odd_div3(input logic [7:0] c);
        logic [15:0] p;
        p = {8'b0, c} * 16'd171;
        return p[9];
    endfunction

    function automatic logic odd_div9(input logic [7:0] c);
        logic [15:0] p;
        p = {8'b0, c} * 16'd228;
        return p[11];
    endfunction

    // pattern in effect for a mode and the time-derived index
    function automatic logic [2:0] pattern_select(input logic [2:0] mode,
                                                  input logic [2:0] time_pat);
        logic [2:0] p;
        if (mode == 3'd0) begin
            p = time_pat;
        end else begin
            p = mode - 3'd1;
        end
        if (p > PAT_LAST) begin
            p = PAT_PULSE3;
        end
        return p;
    endfunction

endpackage

// ===== rtl/vmpg_rem_pattern.sv =====
`timescale 1ns / 1ps
// vmpg_rem_pattern: (remaining / 60) % 6 without a divider.
// Depends on vmpg_pkg.

module vmpg_rem_pattern (
    input  logic [15:0] remaining,
    output logic [2:0]  time_pat
);

    logic [28:0] prod;
    logic [10:0] minutes;
    logic [1:0]  m3;

    // r/60 = (r>>2)/15, reciprocal of 15 exact below 2^14
    assign prod    = {15'b0, remaining[15:2]} * 29'd17477;
    assign minutes = prod[28:18];
    assign m3      = vmpg_pkg::mod3_u11(minutes);

    // recombine residues mod 2 and mod 3 into mod 6
    always_comb begin
        case ({minutes[0], m3})
            3'b000:  time_pat = 3'd0;
            3'b001:  time_pat = 3'd4;
            3'b010:  time_pat = 3'd2;
            3'b100:  time_pat = 3'd3;
            3'b101:  time_pat = 3'd1;
            3'b110:  time_pat = 3'd5;
            default: time_pat = 3'd0;
        endcase
    end

endmodule

// ===== rtl/vmpg_engine.sv =====
`timescale 1ns / 1ps
// vmpg_engine: block state, mode register and the single-pass step logic.
// Depends on vmpg_pkg and vmpg_rem_pattern.

module vmpg_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_wdata,
    input  logic                step_en,
    input  vmpg_pkg::in_item_t  item,
    output vmpg_pkg::out_item_t result
);

    logic [2:0]                 work_mode_reg;
    logic                       active_reg, active_next;
    logic [15:0]                rem_reg, rem_next;
    logic [2:0]                 motor_reg, motor_next;
    logic [vmpg_pkg::PIN_W-1:0] pins_reg, pins_next;
    logic [7:0]                 pat_cnt_reg [5];
    logic [7:0]                 pat_cnt_next [5];
    logic [7:0]                 burst_reg [2];
    logic [7:0]                 burst_next [2];
    logic [2:0]                 rem_pat_reg, rem_pat_next;

    logic [2:0]  step_pat;
    logic [2:0]  cnt_idx;
    logic [7:0]  cnt_inc;
    logic [7:0]  b0_inc, b1_inc;
    logic [15:0] rem_dec;
    logic        drive_en, drive_on;
    logic        motor_ok;

    vmpg_rem_pattern u_rem_pattern (
        .remaining (rem_next),
        .time_pat  (rem_pat_next)
    );

    assign step_pat = vmpg_pkg::pattern_select(work_mode_reg, rem_pat_reg);
    assign cnt_idx  = (step_pat == vmpg_pkg::PAT_ON) ? 3'd0 : step_pat - 3'd1;
    assign cnt_inc  = pat_cnt_reg[cnt_idx] + 8'd1;
    assign b0_inc   = burst_reg[0] + 8'd1;
    assign b1_inc   = burst_reg[1] + 8'd1;
    assign rem_dec  = rem_reg - 16'd1;
    assign motor_ok = (motor_reg >= 3'd1) && (motor_reg <= vmpg_pkg::MOTOR_COUNT);

    always_comb begin
        active_next  = active_reg;
        rem_next     = rem_reg;
        motor_next   = motor_reg;
        pins_next    = pins_reg;
        pat_cnt_next = pat_cnt_reg;
        burst_next   = burst_reg;
        drive_en     = 1'b0;
        drive_on     = 1'b0;
        if (step_en) begin
            unique case (item.func)
                vmpg_pkg::FUNC_START: begin
                    active_next = 1'b1;
                    motor_next  = vmpg_pkg::grade_to_motor(item.grade);
                    rem_next    = item.duration;
                end
                vmpg_pkg::FUNC_STOP: begin
                    active_next = 1'b0;
                    motor_next  = vmpg_pkg::grade_to_motor(item.grade);
                    pins_next   = '0;
                end
                vmpg_pkg::FUNC_PATTERN: begin
                    if (active_reg) begin
                        drive_en = 1'b1;
                        if (step_pat == vmpg_pkg::PAT_ON) begin
                            drive_on = 1'b1;
                        end else begin
                            pat_cnt_next[cnt_idx] = cnt_inc;
                            case (step_pat)
                                vmpg_pkg::PAT_PULSE6:  drive_on = !vmpg_pkg::odd_div6(cnt_inc);
                                vmpg_pkg::PAT_PULSE10: drive_on = !vmpg_pkg::odd_div10(cnt_inc);
                                vmpg_pkg::PAT_PULSE3:  drive_on = !vmpg_pkg::odd_div3(cnt_inc);
                                vmpg_pkg::PAT_BURST2: begin
                                    if (!vmpg_pkg::odd_div9(cnt_inc)) begin
                                        burst_next[0] = b0_inc;
                                        drive_on      = !b0_inc[0];
                                    end
                                end
                                default: begin
                                    if (!vmpg_pkg::odd_div10(cnt_inc)) begin
                                        burst_next[1] = b1_inc;
                                        drive_on = (vmpg_pkg::mod3_u11({3'b0, b1_inc}) == 2'd0);
                                    end
                                end
                            endcase
                        end
                    end
                end
                vmpg_pkg::FUNC_COUNT: begin
                    if (active_reg) begin
                        rem_next = rem_dec;
                        if (rem_dec == 16'd0) begin
                            active_next = 1'b0;
                            motor_next  = vmpg_pkg::grade_to_motor(vmpg_pkg::STOP_GRADE);
                            pins_next   = '0;
                        end
                    end
                end
            endcase
            if (drive_en && motor_ok) begin
                pins_next[motor_reg - 3'd1] = drive_on;
            end
        end
    end

    always_comb begin
        result.motor_drive = pins_next;
        result.running     = active_next;
        result.remaining   = rem_next;
        result.pattern     = vmpg_pkg::pattern_select(work_mode_reg, rem_pat_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_mode_reg <= 3'd0;
            active_reg    <= 1'b0;
            rem_reg       <= 16'd0;
            motor_reg     <= 3'd0;
            pins_reg      <= '0;
            pat_cnt_reg   <= '{default: 8'd0};
            burst_reg     <= '{default: 8'd0};
            rem_pat_reg   <= 3'd0;
        end else begin
            if (cfg_we) begin
                work_mode_reg <= cfg_wdata;
            end
            if (step_en) begin
                active_reg  <= active_next;
                rem_reg     <= rem_next;
                motor_reg   <= motor_next;
                pins_reg    <= pins_next;
                pat_cnt_reg <= pat_cnt_next;
                burst_reg   <= burst_next;
                rem_pat_reg <= rem_pat_next;
            end
        end
    end

endmodule

// ===== rtl/vibration_motor_pattern_generator_top.sv =====
`timescale 1ns / 1ps
// vibration_motor_pattern_generator_top: input register, output register and
// handshake around the step engine. Depends on vmpg_pkg and vmpg_engine.
//
// Usage
//   s_valid / s_ready / s_data carry one command per transfer: start, stop,
//   pattern tick or countdown tick. Every accepted command gives
//   exactly one result on m_valid / m_ready / m_data: motor levels, running
//   flag, remaining time and the pattern index in effect.
//   cfg_we / cfg_wdata write the work mode register directly, no wait;
//   write it only while no command is in flight.
//   An accepted command waits in the input register; it is processed as it
//   moves to the output register, and its result is on m_valid from then on.
//   Throughput: one command per cycle, sustained, as long as m_ready is high.
//   The time-to-pattern divide is a reciprocal multiply feeding a register,
//   so each command is one pass between the input and output registers.
//   When the receiver stalls, the result holds in the output register and one
//   more command waits in the input register; s_ready then drops.
//   Reset (aresetn low, synchronous) stops the motors, clears all counters,
//   the remaining time and the work mode, and empties both registers.

module vibration_motor_pattern_generator_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vmpg_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output vmpg_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_wdata
);

    logic                in_valid_reg;
    vmpg_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    vmpg_pkg::out_item_t out_item_reg;
    vmpg_pkg::out_item_t result;
    logic                advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    vmpg_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step_en   (advance),
        .item      (in_item_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

`ifndef ASSERT_OFF
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed command gave no result");

    a_idle_pins_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.running) |-> (m_data.motor_drive == '0))
        else $error("motor driven while stopped");

    a_pattern_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.pattern <= vmpg_pkg::PAT_LAST))
        else $error("pattern index out of range");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready)
            |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("waiting command lost during stall");
`endif

endmodule
